// ===== sv/pws_pkg.sv =====
// Shared types and constants for the pulse word stream decoder.
package pws_pkg;

   // Width of the per-pulse sample counter and of the running totals.
   localparam int SAMPLE_COUNT_BITS = 16;
   localparam int TOTAL_BITS        = 32;

   localparam logic [SAMPLE_COUNT_BITS-1:0] SAMPLE_COUNT_MAX = '1;

   // Format codes carried in bits 55:52 of a word.
   localparam logic [3:0] FMT_HEADER   = 4'd0;
   localparam logic [3:0] FMT_STATUS   = 4'd1;
   localparam logic [3:0] FMT_SAMPLE11 = 4'd2;
   localparam logic [3:0] FMT_SAMPLE16 = 4'd3;
   localparam logic [3:0] FMT_BAD_MIN  = 4'd8;
   localparam logic [3:0] FMT_BAD_MAX  = 4'd15;

   // Result kind codes on the response channel.
   localparam logic [2:0] KIND_HEADER = 3'd0;
   localparam logic [2:0] KIND_STATUS = 3'd1;
   localparam logic [2:0] KIND_SAMPLE = 3'd2;
   localparam logic [2:0] KIND_ZERO   = 3'd3;
   localparam logic [2:0] KIND_BAD    = 3'd4;
   localparam logic [2:0] KIND_FLUSH  = 3'd5;

   // Index of the final result of a multi-result word.
   localparam logic [1:0] LAST_IDX_SINGLE   = 2'd0;
   localparam logic [1:0] LAST_IDX_SAMPLE11 = 2'd3;
   localparam logic [1:0] LAST_IDX_SAMPLE16 = 2'd2;

   // What a held word does.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_FLUSH,
      OP_ZERO,
      OP_HEADER,
      OP_STATUS,
      OP_SAMPLE11,
      OP_SAMPLE16,
      OP_BAD
   } op_type;

   // One decoded input beat.
   typedef struct packed {
      op_type      op;
      logic [7:0]  channel;
      logic [47:0] payload;
      logic [1:0]  last_idx;
   } item_type;

endpackage

// ===== sv/pws_decode.sv =====
// Classifies one raw input beat into an operation and its fields.
module pws_decode import pws_pkg::*; (
   input  logic [63:0] data_word,
   input  logic        flush,
   output item_type    item
);

   logic [3:0] fmt;

   assign fmt = data_word[55:52];

   // Split the word and pick the operation from flush and format.
   always_comb begin
      item.channel  = data_word[63:56];
      item.payload  = data_word[47:0];
      item.last_idx = LAST_IDX_SINGLE;
      item.op       = OP_NONE;
      if (flush) begin
         item.op = OP_FLUSH;
      end else begin
         unique case (fmt) inside
            FMT_HEADER: begin
               item.op = (data_word == '0) ? OP_ZERO : OP_HEADER;
            end
            FMT_STATUS: begin
               item.op = OP_STATUS;
            end
            FMT_SAMPLE11: begin
               item.op       = OP_SAMPLE11;
               item.last_idx = LAST_IDX_SAMPLE11;
            end
            FMT_SAMPLE16: begin
               item.op       = OP_SAMPLE16;
               item.last_idx = LAST_IDX_SAMPLE16;
            end
            [FMT_BAD_MIN:FMT_BAD_MAX]: begin
               item.op = OP_BAD;
            end
            default: begin
               item.op = OP_NONE;
            end
         endcase
      end
   end

endmodule

// ===== sv/pulse_word_stream_decoder.sv =====
// A word's beat is accepted into the hold register; its results are built from there into the result register.
// One word per cycle for headers, status, zero, bad and flush words unless the output stalls;
// a sample word stays held until all its samples, four or three, have been emitted.
// Formats four to seven pass through the hold register without waiting on the output and give no result.
// Reset is synchronous and clears the pulse state, the totals and both valid flags.
module pulse_word_stream_decoder import pws_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [63:0]        req_data_word,
   input  logic               req_flush,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_result_kind,
   output logic [7:0]         rsp_channel,
   output logic [47:0]        rsp_value48,
   output logic [7:0]         rsp_state_byte,
   output logic signed [15:0] rsp_sample,
   output logic [15:0]        rsp_sample_index,
   output logic               rsp_last,
   output logic               rsp_closed_previous,
   output logic [15:0]        rsp_closed_sample_count,
   output logic [31:0]        rsp_pulse_total,
   output logic [31:0]        rsp_zero_word_total,
   output logic [31:0]        rsp_bad_format_total
);

   item_type decoded;

   // Hold register for the word being worked on.
   logic     hold_valid_ff;
   item_type hold_item_ff;
   logic [1:0] hold_idx_ff;

   // Decoder state.
   logic                         pulse_open_ff, pulse_open_in;
   logic [7:0]                   cur_channel_ff, cur_channel_in;
   logic [SAMPLE_COUNT_BITS-1:0] sample_count_ff, sample_count_in;
   logic [TOTAL_BITS-1:0]        pulse_count_ff, pulse_count_in;
   logic [TOTAL_BITS-1:0]        zero_count_ff, zero_count_in;
   logic [TOTAL_BITS-1:0]        bad_count_ff, bad_count_in;

   // Result register.
   logic               rsp_valid_ff;
   logic [2:0]         kind_ff, kind_in;
   logic [7:0]         channel_ff, channel_in;
   logic [47:0]        value48_ff, value48_in;
   logic [7:0]         state_byte_ff, state_byte_in;
   logic signed [15:0] sample_ff, sample_in;
   logic [15:0]        sample_index_ff, sample_index_in;
   logic               last_ff, last_in;
   logic               closed_ff, closed_in;
   logic [15:0]        closed_count_ff, closed_count_in;
   logic [31:0]        pulse_total_ff, zero_total_ff, bad_total_ff;

   logic        out_free;
   logic        no_result;
   logic        emit;
   logic        is_last;
   logic        hold_done;
   logic        accept;
   logic [10:0] raw11;
   logic [15:0] raw16;

   pws_decode u_decode (
      .data_word (req_data_word),
      .flush     (req_flush),
      .item      (decoded)
   );

   // Handshake control between hold and result registers.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign no_result = (hold_item_ff.op == OP_NONE);
   assign emit      = hold_valid_ff && !no_result && out_free;
   assign is_last   = (hold_idx_ff == hold_item_ff.last_idx);
   assign hold_done = hold_valid_ff && (no_result || (out_free && is_last));
   assign req_ready = !hold_valid_ff || hold_done;
   assign accept    = req_valid && req_ready;

   // Select the sample field addressed by the result index.
   always_comb begin
      case (hold_idx_ff)
         2'd0: raw11 = hold_item_ff.payload[10:0];
         2'd1: raw11 = hold_item_ff.payload[22:12];
         2'd2: raw11 = hold_item_ff.payload[34:24];
         default: raw11 = hold_item_ff.payload[46:36];
      endcase
      case (hold_idx_ff)
         2'd0: raw16 = hold_item_ff.payload[15:0];
         2'd1: raw16 = hold_item_ff.payload[31:16];
         2'd2: raw16 = hold_item_ff.payload[47:32];
         default: raw16 = '0;
      endcase
   end

   // Build the next result and the state it leaves behind.
   always_comb begin
      pulse_open_in   = pulse_open_ff;
      cur_channel_in  = cur_channel_ff;
      sample_count_in = sample_count_ff;
      pulse_count_in  = pulse_count_ff;
      zero_count_in   = zero_count_ff;
      bad_count_in    = bad_count_ff;
      kind_in         = KIND_FLUSH;
      channel_in      = '0;
      value48_in      = '0;
      state_byte_in   = '0;
      sample_in       = '0;
      sample_index_in = '0;
      last_in         = is_last;
      closed_in       = 1'b0;
      closed_count_in = '0;
      unique case (hold_item_ff.op)
         OP_FLUSH: begin
            kind_in         = KIND_FLUSH;
            channel_in      = cur_channel_ff;
            closed_in       = pulse_open_ff;
            closed_count_in = pulse_open_ff ? 16'(sample_count_ff) : 16'd0;
            pulse_open_in   = 1'b0;
            sample_count_in = '0;
         end
         OP_ZERO: begin
            kind_in       = KIND_ZERO;
            zero_count_in = zero_count_ff + 1'b1;
         end
         OP_HEADER: begin
            kind_in         = KIND_HEADER;
            channel_in      = hold_item_ff.channel;
            value48_in      = hold_item_ff.payload;
            closed_in       = pulse_open_ff;
            closed_count_in = pulse_open_ff ? 16'(sample_count_ff) : 16'd0;
            pulse_count_in  = pulse_count_ff + 1'b1;
            pulse_open_in   = 1'b1;
            cur_channel_in  = hold_item_ff.channel;
            sample_count_in = '0;
         end
         OP_STATUS: begin
            kind_in       = KIND_STATUS;
            channel_in    = hold_item_ff.channel;
            value48_in    = {8'd0, hold_item_ff.payload[39:0]};
            state_byte_in = hold_item_ff.payload[47:40];
         end
         OP_SAMPLE11, OP_SAMPLE16: begin
            kind_in         = KIND_SAMPLE;
            channel_in      = cur_channel_ff;
            sample_in       = (hold_item_ff.op == OP_SAMPLE11) ?
                              16'($signed(raw11)) : $signed(raw16);
            sample_index_in = 16'(sample_count_ff);
            if (sample_count_ff != SAMPLE_COUNT_MAX) begin
               sample_count_in = sample_count_ff + 1'b1;
            end
         end
         OP_BAD: begin
            kind_in      = KIND_BAD;
            channel_in   = hold_item_ff.channel;
            bad_count_in = bad_count_ff + 1'b1;
         end
         default: begin
            kind_in = KIND_FLUSH;
         end
      endcase
   end

   // Hold register: load on accept, step the result index while emitting.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         hold_idx_ff   <= '0;
      end else if (accept) begin
         hold_valid_ff <= 1'b1;
         hold_idx_ff   <= '0;
      end else if (hold_done) begin
         hold_valid_ff <= 1'b0;
      end else if (emit) begin
         hold_idx_ff <= hold_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_item_ff <= decoded;
      end
   end

   // Decoder state advances with each result that leaves.
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_open_ff   <= 1'b0;
         cur_channel_ff  <= '0;
         sample_count_ff <= '0;
         pulse_count_ff  <= '0;
         zero_count_ff   <= '0;
         bad_count_ff    <= '0;
      end else if (emit) begin
         pulse_open_ff   <= pulse_open_in;
         cur_channel_ff  <= cur_channel_in;
         sample_count_ff <= sample_count_in;
         pulse_count_ff  <= pulse_count_in;
         zero_count_ff   <= zero_count_in;
         bad_count_ff    <= bad_count_in;
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff         <= kind_in;
         channel_ff      <= channel_in;
         value48_ff      <= value48_in;
         state_byte_ff   <= state_byte_in;
         sample_ff       <= sample_in;
         sample_index_ff <= sample_index_in;
         last_ff         <= last_in;
         closed_ff       <= closed_in;
         closed_count_ff <= closed_count_in;
         pulse_total_ff  <= 32'(pulse_count_in);
         zero_total_ff   <= 32'(zero_count_in);
         bad_total_ff    <= 32'(bad_count_in);
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_result_kind         = kind_ff;
   assign rsp_channel             = channel_ff;
   assign rsp_value48             = value48_ff;
   assign rsp_state_byte          = state_byte_ff;
   assign rsp_sample              = sample_ff;
   assign rsp_sample_index        = sample_index_ff;
   assign rsp_last                = last_ff;
   assign rsp_closed_previous     = closed_ff;
   assign rsp_closed_sample_count = closed_count_ff;
   assign rsp_pulse_total         = pulse_total_ff;
   assign rsp_zero_word_total     = zero_total_ff;
   assign rsp_bad_format_total    = bad_total_ff;

endmodule
